### sv/multi_mode_byte_checksum_assert.svh
// Assertion macros for the byte checksum block.
`ifndef MULTI_MODE_BYTE_CHECKSUM_ASSERT_SVH
`define MULTI_MODE_BYTE_CHECKSUM_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MMBC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define MMBC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MMBC_ASSERT_SAME(name, clk, rst, ante, cons)

`define MMBC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### sv/mmbc_pkg.sv
package mmbc_pkg;

   localparam int COUNT_BITS_DEFAULT = 48;
   localparam int OUT_COUNT_BITS     = 48;
   localparam int CHECKSUM_BITS      = 32;
   localparam int SUM16_BITS         = 16;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [7:0]  TRAIL_XOR_A = 8'hCC;
   localparam logic [7:0]  TRAIL_XOR_B = 8'h55;

   // 512-byte and 1024-byte blocks
   localparam int SYSV_BLOCK_SHIFT = 9;
   localparam int ROT_BLOCK_SHIFT  = 10;

   typedef enum logic [1:0] {
      MODE_CRC  = 2'd0,
      MODE_SYSV = 2'd1,
      MODE_ROT  = 2'd2
   } sum_mode_type;

   function automatic logic [31:0] crc_entry(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      return (crc >> 8) ^ crc_entry(crc[7:0] ^ b);
   endfunction

endpackage

### sv/multi_mode_byte_checksum.sv
// A tlast beat passes end-of-file capture and the trailer stage before rsp_tvalid shows it.
// Throughput: one beat per cycle (the per-byte CRC table step sets it) unless a tlast beat
// waits for room in end-of-file capture. The result path has two internal stages plus the
// output register, so results stream without stalling the input unless all three are full.
// Reset (synchronous): clears accumulator, byte count, pipeline valids; mode returns to MODE_CRC.
`include "multi_mode_byte_checksum_assert.svh"

module multi_mode_byte_checksum #(
   parameter int COUNT_BITS = mmbc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // byte_present
   input  logic         req_tlast,   // end_of_file

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [31:0] checksum, [79:32] total_bytes,
                                     // [127:80] block_total

   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data  // sum_mode
);

   localparam int OB = mmbc_pkg::OUT_COUNT_BITS;

   // configuration
   mmbc_pkg::sum_mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mmbc_pkg::MODE_CRC;
      end else if (csr_wr_en) begin
         mode_ff <= mmbc_pkg::sum_mode_type'(csr_wr_data);
      end
   end

   // handshake chain
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic a_last_ff, a_present_ff;
   logic [7:0] a_byte_ff;
   logic rsp_free, c_free, b_free, c_adv, b_adv, a_adv;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign c_adv      = c_valid_ff && rsp_free;
   assign c_free     = !c_valid_ff || rsp_free;
   assign b_adv      = b_valid_ff && c_free;
   assign b_free     = !b_valid_ff || c_free;
   assign a_adv      = a_valid_ff && (!a_last_ff || b_free);
   assign req_tready = !a_valid_ff || a_adv;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         a_byte_ff    <= req_tdata;
         a_present_ff <= req_tuser;
         a_last_ff    <= req_tlast;
      end
   end

   // running state
   logic [31:0]           acc_ff, acc_upd, acc_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_upd, cnt_in;
   logic [15:0]           rot_sum;

   assign rot_sum = acc_ff[16:1] + {8'd0, a_byte_ff} + {acc_ff[0], 15'd0};

   always_comb begin
      acc_upd = acc_ff;
      cnt_upd = cnt_ff;
      if (a_present_ff) begin
         cnt_upd = cnt_ff + COUNT_BITS'(1);
         unique case (mode_ff)
            mmbc_pkg::MODE_CRC:  acc_upd = mmbc_pkg::crc_step(acc_ff, a_byte_ff);
            mmbc_pkg::MODE_SYSV: acc_upd = acc_ff + {24'd0, a_byte_ff};
            mmbc_pkg::MODE_ROT:  acc_upd = {16'd0, rot_sum};
            default:             acc_upd = acc_ff;
         endcase
      end
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (a_adv) begin
         if (a_last_ff) begin
            acc_in = '0;
            cnt_in = '0;
         end else begin
            acc_in = acc_upd;
            cnt_in = cnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   // end-of-file capture
   logic [31:0]            b_acc_ff;
   logic [COUNT_BITS-1:0]  b_cnt_ff;
   mmbc_pkg::sum_mode_type b_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_free) begin
         b_valid_ff <= a_adv && a_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free && a_adv && a_last_ff) begin
         b_acc_ff  <= acc_upd;
         b_cnt_ff  <= cnt_upd;
         b_mode_ff <= mode_ff;
      end
   end

   // first half of trailer, fold, block rounding
   logic [31:0]            c_check_in, c_check_ff, crc_half;
   logic [15:0]            c_nlo_ff;
   logic [OB-1:0]          c_total_in, c_total_ff, c_blocks_in, c_blocks_ff;
   mmbc_pkg::sum_mode_type c_mode_ff;
   logic [COUNT_BITS-1:0]  blk_sysv, blk_rot;
   logic [63:0]            cnt_ext, blk_sysv_ext, blk_rot_ext;
   logic [15:0]            sysv_fold;

   assign crc_half = mmbc_pkg::crc_step(
                        mmbc_pkg::crc_step(b_acc_ff, b_cnt_ff[31:24] ^ mmbc_pkg::TRAIL_XOR_A),
                        b_cnt_ff[23:16] ^ mmbc_pkg::TRAIL_XOR_B);
   assign sysv_fold = b_acc_ff[31:16] + b_acc_ff[15:0];

   assign blk_sysv = (b_cnt_ff >> mmbc_pkg::SYSV_BLOCK_SHIFT)
                   + COUNT_BITS'(|b_cnt_ff[mmbc_pkg::SYSV_BLOCK_SHIFT-1:0]);
   assign blk_rot  = (b_cnt_ff >> mmbc_pkg::ROT_BLOCK_SHIFT)
                   + COUNT_BITS'(|b_cnt_ff[mmbc_pkg::ROT_BLOCK_SHIFT-1:0]);
   assign cnt_ext      = 64'(b_cnt_ff);
   assign blk_sysv_ext = 64'(blk_sysv);
   assign blk_rot_ext  = 64'(blk_rot);
   assign c_total_in   = cnt_ext[OB-1:0];

   always_comb begin
      unique case (b_mode_ff)
         mmbc_pkg::MODE_CRC: begin
            c_check_in  = crc_half;
            c_blocks_in = '0;
         end
         mmbc_pkg::MODE_SYSV: begin
            c_check_in  = {16'd0, sysv_fold};
            c_blocks_in = blk_sysv_ext[OB-1:0];
         end
         mmbc_pkg::MODE_ROT: begin
            c_check_in  = {16'd0, b_acc_ff[15:0]};
            c_blocks_in = blk_rot_ext[OB-1:0];
         end
         default: begin
            c_check_in  = '0;
            c_blocks_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_free) begin
         c_valid_ff <= b_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_check_ff  <= c_check_in;
         c_nlo_ff    <= b_cnt_ff[15:0];
         c_total_ff  <= c_total_in;
         c_blocks_ff <= c_blocks_in;
         c_mode_ff   <= b_mode_ff;
      end
   end

   // second half of trailer, output register
   logic [31:0]   rsp_check_in, rsp_check_ff;
   logic [OB-1:0] rsp_total_ff, rsp_blocks_ff;

   assign rsp_check_in = (c_mode_ff == mmbc_pkg::MODE_CRC) ?
      mmbc_pkg::crc_step(
         mmbc_pkg::crc_step(c_check_ff, c_nlo_ff[15:8] ^ mmbc_pkg::TRAIL_XOR_A),
         c_nlo_ff[7:0] ^ mmbc_pkg::TRAIL_XOR_B) : c_check_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= c_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv) begin
         rsp_check_ff  <= rsp_check_in;
         rsp_total_ff  <= c_total_ff;
         rsp_blocks_ff <= c_blocks_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_blocks_ff, rsp_total_ff, rsp_check_ff};

   `MMBC_ASSERT_NEXT(a_eof_reaches_capture, clock, reset, a_adv && a_last_ff, b_valid_ff)
   `MMBC_ASSERT_NEXT(a_eof_clears_state, clock, reset, a_adv && a_last_ff,
                     acc_ff == '0 && cnt_ff == '0)
   `MMBC_ASSERT_NEXT(b_hold_on_stall, clock, reset, b_valid_ff && !c_free,
                     b_valid_ff && $stable(b_cnt_ff) && $stable(b_acc_ff))
   `MMBC_ASSERT_SAME(eof_waits_for_room, clock, reset, a_valid_ff && a_last_ff && !b_free,
                     !req_tready)

endmodule
